FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the integer-to-text converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: src/itr_pkg.sv
// ----------------------------------------------------------------------------
// itr_pkg
// Types, constants and helper functions shared by the converter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itr_pkg;

   // Radix register limits and reset value.
   localparam logic [5:0] RADIX_MIN   = 6'd2;
   localparam logic [5:0] RADIX_MAX   = 6'd36;
   localparam logic [5:0] RADIX_RESET = 6'd10;

   // Character codes.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Largest number of digits (base two, magnitude two to the 31st).
   localparam int         DIGIT_CAP  = 32;
   localparam logic [5:0] DIGIT_MAX  = 6'd32;

   // Depth of the queue between the front and the back.
   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   // One classified transaction waiting for conversion.
   typedef struct packed {
      logic        negative;
      logic [31:0] magnitude;
      logic [5:0]  base;
   } item_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Clamp the programmed radix into the supported range.
   function automatic logic [5:0] clamp_radix(input logic [5:0] r);
      if (r < RADIX_MIN) begin
         return RADIX_MIN;
      end
      if (r > RADIX_MAX) begin
         return RADIX_MAX;
      end
      return r;
   endfunction

   // Map a digit value 0..35 to its character.
   function automatic logic [7:0] digit_char(input logic [5:0] d);
      if (d > 6'd9) begin
         return CHAR_UPPER + {2'b00, d} - 8'd10;
      end
      return CHAR_ZERO + {2'b00, d};
   endfunction

endpackage

FILE: src/itr_front.sv
// ----------------------------------------------------------------------------
// itr_front
// Holds the radix register, accepts transactions and splits each number
// into sign and magnitude before it enters the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              req_number,
   input  logic                     csr_valid,
   input  logic [5:0]               csr_data,
   input  itr_pkg::queue_status_type q_status,
   output logic                     push,
   output itr_pkg::item_type        item
);

   logic [5:0] radix_ff;
   logic [5:0] radix_in;

   // Radix register write.
   always_comb begin
      radix_in = radix_ff;
      if (csr_valid) begin
         radix_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itr_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // Accept whenever the queue has room; negation also covers the most
   // negative value, whose magnitude wraps to two to the 31st.
   assign push = start && !q_status.full;

   always_comb begin
      item.negative  = req_number[31];
      item.magnitude = req_number[31] ? (32'd0 - req_number) : req_number;
      item.base      = itr_pkg::clamp_radix(radix_ff);
   end

endmodule

FILE: src/itr_queue.sv
// ----------------------------------------------------------------------------
// itr_queue
// Two-entry queue that decouples transaction acceptance from conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  itr_pkg::item_type         din,
   input  logic                      pop,
   output itr_pkg::item_type         dout,
   output itr_pkg::queue_status_type status
);

   itr_pkg::item_type mem_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == itr_pkg::QUEUE_DEPTH);
   assign status.empty = (count_ff == 2'd0);

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= itr_pkg::QUEUE_DEPTH,
      "queue fill count beyond depth")

endmodule

FILE: src/itr_back.sv
// ----------------------------------------------------------------------------
// itr_back
// Extracts digits by repeated division by the radix, eight quotient bits per
// cycle, keeps them on a digit stack and emits the characters in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  itr_pkg::item_type         item,
   input  itr_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_strobe,
   output logic [7:0]                rsp_ascii_code,
   output logic                      rsp_last_char
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]  state_ff;
   logic [1:0]  state_in;
   logic [31:0] num_ff;
   logic [31:0] num_in;
   logic [5:0]  rem_ff;
   logic [5:0]  rem_in;
   logic [1:0]  step_ff;
   logic [1:0]  step_in;
   logic        neg_ff;
   logic        neg_in;
   logic [5:0]  base_ff;
   logic [5:0]  base_in;
   logic [5:0]  ndig_ff;
   logic [5:0]  ndig_in;
   logic [5:0]  digit_ff [itr_pkg::DIGIT_CAP];
   logic        digit_we;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [7:0]  rsp_code_ff;
   logic [7:0]  rsp_code_in;
   logic        rsp_last_ff;
   logic        rsp_last_in;

   logic [31:0] div_num;
   logic [5:0]  div_rem;
   logic [5:0]  ndig_dec;
   logic [5:0]  top_digit;

   // Eight restoring division steps on the narrow remainder.
   always_comb begin
      logic [6:0] part;
      logic [6:0] diff;
      logic [5:0] r;
      logic [31:0] n;
      r = rem_ff;
      n = num_ff;
      for (int i = 0; i < 8; i++) begin
         part = {r, n[31]};
         diff = part - {1'b0, base_ff};
         n    = {n[30:0], 1'b0};
         if (part >= {1'b0, base_ff}) begin
            r    = diff[5:0];
            n[0] = 1'b1;
         end else begin
            r = part[5:0];
         end
      end
      div_num = n;
      div_rem = r;
   end

   // Digit stack read for the character to emit next.
   assign ndig_dec  = ndig_ff - 6'd1;
   assign top_digit = digit_ff[ndig_dec[4:0]];

   assign pop = (state_ff == ST_IDLE) && !q_status.empty;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      ndig_in      = ndig_ff;
      digit_we     = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               num_in   = item.magnitude;
               neg_in   = item.negative;
               base_in  = item.base;
               rem_in   = 6'd0;
               step_in  = 2'd0;
               ndig_in  = 6'd0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            num_in  = div_num;
            rem_in  = div_rem;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               // A full quotient is ready: push the remainder as a digit.
               digit_we = 1'b1;
               ndig_in  = ndig_ff + 6'd1;
               rem_in   = 6'd0;
               if (div_num == 32'd0) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = itr_pkg::CHAR_MINUS;
            rsp_last_in  = 1'b0;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = itr_pkg::digit_char(top_digit);
            rsp_last_in  = (ndig_ff == 6'd1);
            ndig_in      = ndig_dec;
            if (ndig_ff == 6'd1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ndig_ff      <= 6'd0;
         step_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ndig_ff      <= ndig_in;
         step_ff      <= step_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      base_ff     <= base_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
      if (digit_we) begin
         digit_ff[ndig_ff[4:0]] <= div_rem;
      end
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_ascii_code = rsp_code_ff;
   assign rsp_last_char  = rsp_last_ff;

   `ASSERT_CLK(a_ndig_bound, clock, reset, ndig_ff <= itr_pkg::DIGIT_MAX,
      "digit stack overflow")
   `ASSERT_CLK(a_rem_below_base, clock, reset, (state_ff == ST_DIV) |-> (rem_ff < base_ff),
      "partial remainder not below radix")
   `ASSERT_NEVER(a_emit_empty, clock, reset, (state_ff == ST_EMIT) && (ndig_ff == 6'd0),
      "emit with empty digit stack")
   `ASSERT_CLK(a_last_ends_run, clock, reset,
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == ST_IDLE),
      "last character emitted while conversion continues")

endmodule

FILE: src/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts signed 32-bit integers to ASCII text in a programmable base.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                    Handshake
//  request   start, busy, req_number                  start && !busy
//  response  rsp_strobe, rsp_ascii_code, rsp_last_char one-cycle strobe
//  config    csr_valid, csr_ready, csr_data           csr_valid && csr_ready
//
//  Each digit is the remainder of a full division by the shared divider
//  (eight quotient bits a cycle); the characters are then shown, a minus sign
//  first, then the digits from the most significant, at most 32 (base two).
//  Two transactions can wait in the queue; busy is high while it is full.
//  Reset restores radix 10 and empties the queue; csr_ready is always high.
//  The receiver cannot stall: each character is shown for one cycle only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_ascii_radix (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_number,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_ascii_code,
   output logic        rsp_last_char,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data
);

   itr_pkg::queue_status_type q_status;
   itr_pkg::item_type         front_item;
   itr_pkg::item_type         back_item;
   logic                      push;
   logic                      pop;

   // Front: radix register and classification.
   itr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_number (req_number),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push       (push),
      .item       (front_item)
   );

   // Queue between front and back.
   itr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .din    (front_item),
      .pop    (pop),
      .dout   (back_item),
      .status (q_status)
   );

   // Back: digit extraction and character output.
   itr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item           (back_item),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_ascii_code (rsp_ascii_code),
      .rsp_last_char  (rsp_last_char)
   );

   assign busy      = q_status.full;
   assign csr_ready = 1'b1;

endmodule

FILE: dv/integer_to_ascii_radix_checker.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_checker
// Watches the request, response and register channels of the converter,
// predicts the text of every accepted number in the current base and checks
// each character and its end-of-text flag as it is shown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_ascii_radix_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_number,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_ascii_code,
   input  logic        rsp_last_char,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [5:0]  csr_data,
   output int          error_count,
   output int          chars_pending
);

   import itr_pkg::*;

   // One predicted character, with the number and base it came from.
   typedef struct {
      logic [7:0]  code;
      logic        last;
      logic [31:0] source;
      logic [5:0]  base;
   } text_char_type;

   text_char_type expected_text[$];
   logic [5:0] radix_shadow = RADIX_RESET;
   int         mismatches   = 0;
   int         pending      = 0;

   assign error_count   = mismatches;
   assign chars_pending = pending;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Queue the characters of one number written in the given base register value.
   function automatic void predict_text(input logic [31:0] value, input logic [5:0] radix_reg);
      logic          negative;
      logic [31:0]   mag;
      logic [31:0]   base32;
      logic [5:0]    base;
      logic [5:0]    digit;
      logic [7:0]    digits[$];
      text_char_type ch;
      negative = value[31];
      mag      = negative ? (32'd0 - value) : value;
      // Register values outside two to thirty-six are pinned to the nearer end.
      if (radix_reg < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix_reg > RADIX_MAX) begin
         base = RADIX_MAX;
      end else begin
         base = radix_reg;
      end
      base32 = {26'd0, base};
      // Least significant digit first; zero still yields one digit.
      do begin
         digit = 6'(mag % base32);
         if (digit < 6'd10) begin
            digits.push_back(CHAR_ZERO + {2'b00, digit});
         end else begin
            digits.push_back(CHAR_UPPER + {2'b00, digit} - 8'd10);
         end
         mag = mag / base32;
      end while (mag != 32'd0);
      ch.source = value;
      ch.base   = base;
      if (negative) begin
         ch.code = CHAR_MINUS;
         ch.last = 1'b0;
         expected_text.push_back(ch);
      end
      for (int k = digits.size() - 1; k >= 0; k--) begin
         ch.code = digits[k];
         ch.last = (k == 0);
         expected_text.push_back(ch);
      end
   endfunction

   // All channel signals are sampled at the rising edge, before any update.
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         expected_text.delete();
         radix_shadow = RADIX_RESET;
      end else begin
         // Check a shown character against the oldest prediction.
         if (rsp_strobe !== 1'b0) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("character 0x%02h shown with none expected",
                                         rsp_ascii_code));
            end else begin
               want = expected_text.pop_front();
               if (rsp_ascii_code !== want.code) begin
                  report_mismatch($sformatf("number %0d base %0d: character 0x%02h, expected 0x%02h",
                                            $signed(want.source), want.base,
                                            rsp_ascii_code, want.code));
               end
               if (rsp_last_char !== want.last) begin
                  report_mismatch($sformatf("number %0d base %0d: last flag %b, expected %b",
                                            $signed(want.source), want.base,
                                            rsp_last_char, want.last));
               end
            end
         end
         // A request transaction adds its whole text to the prediction.
         if (start && !busy) begin
            predict_text(req_number, radix_shadow);
         end
         // A register transaction changes the base of later requests.
         if (csr_valid && csr_ready) begin
            radix_shadow = csr_data;
         end
      end
      pending = expected_text.size();
   end

endmodule

FILE: dv/tb_integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix
// Drives numbers and base settings into the integer-to-text converter with
// random gaps, lets the checker predict and compare every character, and
// gives the verdict once all text has come out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_integer_to_ascii_radix;

   import itr_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int TAIL_CYCLES  = 200;
   localparam int PHASE_ITEMS  = 30;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        start      = 1'b0;
   logic [31:0] req_number = 32'd0;
   logic        csr_valid  = 1'b0;
   logic [5:0]  csr_data   = 6'd0;
   logic        busy;
   logic        rsp_strobe;
   logic [7:0]  rsp_ascii_code;
   logic        rsp_last_char;
   logic        csr_ready;
   int          error_count;
   int          chars_pending;
   int          cycle_count = 0;

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   integer_to_ascii_radix uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_number     (req_number),
      .rsp_strobe     (rsp_strobe),
      .rsp_ascii_code (rsp_ascii_code),
      .rsp_last_char  (rsp_last_char),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   integer_to_ascii_radix_checker text_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_number     (req_number),
      .rsp_strobe     (rsp_strobe),
      .rsp_ascii_code (rsp_ascii_code),
      .rsp_last_char  (rsp_last_char),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .error_count    (error_count),
      .chars_pending  (chars_pending)
   );

   // Hard stop in case the converter hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // The tasks below are entered and left just after a rising edge; levels
   // are sampled at the falling edge, where nothing is changing.

   // Write the base register in one transaction.
   task automatic write_radix(input logic [5:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offer one number and hold it until the request transaction completes.
   task automatic send_number(input logic [31:0] value);
      start      <= 1'b1;
      req_number <= value;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // Send a number and then idle for a drawn number of cycles.
   task automatic send_with_gap(input logic [31:0] value, input bit no_idle);
      int gap;
      send_number(value);
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every predicted character has been shown.
   task automatic drain_text;
      start <= 1'b0;
      @(negedge clock);
      while (chars_pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Draw a number that exercises the digit count for the given register value.
   function automatic logic [31:0] pick_number(input logic [5:0] radix_reg);
      logic [31:0] value;
      longint      power;
      int          base;
      int          steps;
      base = (radix_reg < RADIX_MIN) ? 2 : (radix_reg > RADIX_MAX) ? 36 : int'(radix_reg);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: value = $urandom;
         4, 5:       value = $urandom_range(0, 2000);
         6: begin
            case ($urandom_range(0, 4))
               0:       value = 32'h8000_0000;
               1:       value = 32'h7FFF_FFFF;
               2:       value = 32'd0;
               3:       value = 32'd1;
               default: value = 32'hFFFF_FFFF;
            endcase
         end
         7, 8: begin
            // A power of the base, or one off it, changes the digit count.
            power = 1;
            steps = $urandom_range(1, 31);
            repeat (steps) begin
               if (power * base <= 64'sh7FFF_FFFF) begin
                  power = power * base;
               end
            end
            value = 32'(power) + 32'($urandom_range(0, 2)) - 32'd1;
         end
         default: value = $urandom >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 1) == 1) begin
         value = 32'd0 - value;
      end
      return value;
   endfunction

   // One base setting followed by a run of random numbers.
   task automatic run_random_phase(input logic [5:0] radix_reg, input bit no_idle);
      write_radix(radix_reg);
      repeat (PHASE_ITEMS) send_with_gap(pick_number(radix_reg), no_idle);
      drain_text();
   endtask

   logic [5:0] phase_radix[12] = '{6'd10, 6'd16, 6'd8, 6'd3, 6'd1, 6'd37,
                                   6'd2, 6'd36, 6'd7, 6'd63, 6'd0, 6'd0};

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Decimal after reset: zero, signs, both ends of the range.
      send_with_gap(32'd0, 1'b0);
      send_with_gap(32'd1, 1'b0);
      send_with_gap(32'hFFFF_FFFF, 1'b1);
      send_with_gap(32'd9, 1'b1);
      send_with_gap(32'd10, 1'b0);
      send_with_gap(32'hFFFF_FFF6, 1'b0);
      send_with_gap(32'h7FFF_FFFF, 1'b1);
      send_with_gap(32'h8000_0000, 1'b1);
      send_with_gap(32'h8000_0001, 1'b0);
      send_with_gap(32'd1000000000, 1'b0);
      drain_text();

      // Base thirty-six: the highest digit and the most negative value.
      write_radix(6'd36);
      send_with_gap(32'd35, 1'b0);
      send_with_gap(32'd36, 1'b1);
      send_with_gap(32'hFFFF_FFDD, 1'b0);
      send_with_gap(32'd1295, 1'b1);
      send_with_gap(32'h8000_0000, 1'b0);
      drain_text();

      // Base two: the longest text of all is the most negative value.
      write_radix(6'd2);
      send_with_gap(32'h8000_0000, 1'b1);
      send_with_gap(32'h7FFF_FFFF, 1'b1);
      send_with_gap(32'hFFFF_FFFF, 1'b0);
      drain_text();

      // Register values below two behave as base two.
      write_radix(6'd0);
      send_with_gap(32'd5, 1'b0);
      send_with_gap(32'hFFFF_FFFB, 1'b1);
      drain_text();

      // Register values above thirty-six behave as base thirty-six.
      write_radix(6'd63);
      send_with_gap(32'd35, 1'b1);
      send_with_gap(32'hFFFF_FFB9, 1'b0);
      drain_text();
      write_radix(6'd37);
      send_with_gap(32'd36, 1'b0);
      drain_text();

      // Random numbers over a spread of bases; every third phase runs back to back.
      phase_radix[10] = 6'($urandom_range(2, 36));
      phase_radix[11] = 6'($urandom_range(0, 63));
      for (int p = 0; p < 12; p++) begin
         run_random_phase(phase_radix[p], (p % 3) == 1);
      end

      // Allow for any stray character after the last expected one.
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
